@@ sv/segi_pkg.sv @@
`default_nettype none
package segi_pkg;

    localparam int COORD_BITS = 16;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int NW = 2 * COORD_BITS + 3;
    localparam int QW = NW + DW;

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
        logic                         extend_first;
    } t_seg_in;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         clipped;
    } t_seg_out;

endpackage
`default_nettype wire

@@ sv/segment_intersection.sv @@
// Segment intersection pipeline. Takes one pair of segments per cycle and returns one
// result per pair, in order. It has six stages for the differences, cross products,
// denominator and numerators, sign normalization, range checks and the two numerator
// products, then one restoring division step per quotient bit for each of x and y, then
// the saturating output register. The whole pipeline stalls together while the output
// register holds a result that is not taken.
`default_nettype none
module segment_intersection
    import segi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_seg_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_seg_out      o_out_data
);

    localparam int C = COORD_BITS;

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: differences
    logic                 r_v1;
    logic signed [DW-1:0] r1_dax, r1_day, r1_dbx, r1_dby, r1_wx, r1_wy;
    logic signed [C-1:0]  r1_x1, r1_y1;
    logic                 r1_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dax <= DW'(i_in_data.first_end_x) - DW'(i_in_data.first_start_x);
            r1_day <= DW'(i_in_data.first_end_y) - DW'(i_in_data.first_start_y);
            r1_dbx <= DW'(i_in_data.second_end_x) - DW'(i_in_data.second_start_x);
            r1_dby <= DW'(i_in_data.second_end_y) - DW'(i_in_data.second_start_y);
            r1_wx  <= DW'(i_in_data.second_start_x) - DW'(i_in_data.first_start_x);
            r1_wy  <= DW'(i_in_data.second_start_y) - DW'(i_in_data.first_start_y);
            r1_x1  <= i_in_data.first_start_x;
            r1_y1  <= i_in_data.first_start_y;
            r1_ext <= i_in_data.extend_first;
        end
    end

    // stage 2: cross products
    logic                 r_v2;
    logic signed [PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DW-1:0] r2_dax, r2_day;
    logic signed [C-1:0]  r2_x1, r2_y1;
    logic                 r2_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p0  <= PW'(r1_dbx) * PW'(r1_day);
            r2_p1  <= PW'(r1_dax) * PW'(r1_dby);
            r2_p2  <= PW'(r1_dbx) * PW'(r1_wy);
            r2_p3  <= PW'(r1_wx) * PW'(r1_dby);
            r2_p4  <= PW'(r1_dax) * PW'(r1_wy);
            r2_p5  <= PW'(r1_wx) * PW'(r1_day);
            r2_dax <= r1_dax;
            r2_day <= r1_day;
            r2_x1  <= r1_x1;
            r2_y1  <= r1_y1;
            r2_ext <= r1_ext;
        end
    end

    // stage 3: denominator and numerators
    logic                 r_v3;
    logic signed [NW-1:0] r3_den, r3_sn, r3_tn;
    logic signed [DW-1:0] r3_dax, r3_day;
    logic signed [C-1:0]  r3_x1, r3_y1;
    logic                 r3_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_den <= NW'(r2_p0) - NW'(r2_p1);
            r3_sn  <= NW'(r2_p2) - NW'(r2_p3);
            r3_tn  <= NW'(r2_p4) - NW'(r2_p5);
            r3_dax <= r2_dax;
            r3_day <= r2_day;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
            r3_ext <= r2_ext;
        end
    end

    // stage 4: make the denominator positive
    logic                 r_v4;
    logic signed [NW-1:0] r4_den, r4_sn, r4_tn;
    logic                 r4_zero;
    logic signed [DW-1:0] r4_dax, r4_day;
    logic signed [C-1:0]  r4_x1, r4_y1;
    logic                 r4_ext;
    logic                 dneg;

    assign dneg = r3_den[NW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_den  <= dneg ? -r3_den : r3_den;
            r4_sn   <= dneg ? -r3_sn : r3_sn;
            r4_tn   <= dneg ? -r3_tn : r3_tn;
            r4_zero <= (r3_den == '0);
            r4_dax  <= r3_dax;
            r4_day  <= r3_day;
            r4_x1   <= r3_x1;
            r4_y1   <= r3_y1;
            r4_ext  <= r3_ext;
        end
    end

    // stage 5: range checks, magnitudes and quotient signs
    logic                 r_v5;
    logic                 r5_hit, r5_negx, r5_negy;
    logic [NW-1:0]        r5_sm, r5_den;
    logic [DW-1:0]        r5_adx, r5_ady;
    logic signed [C-1:0]  r5_x1, r5_y1;
    logic signed [NW-1:0] t_gap, s_gap;
    logic                 t_ok, s_ok;

    assign t_gap = r4_den - r4_tn;
    assign s_gap = r4_den - r4_sn;
    assign t_ok  = !r4_tn[NW-1] && !t_gap[NW-1];
    assign s_ok  = !r4_sn[NW-1] && !s_gap[NW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit  <= !r4_zero && t_ok && (s_ok || r4_ext);
            r5_sm   <= r4_sn[NW-1] ? NW'(-r4_sn) : NW'(r4_sn);
            r5_den  <= r4_den;
            r5_adx  <= r4_dax[DW-1] ? DW'(-r4_dax) : DW'(r4_dax);
            r5_ady  <= r4_day[DW-1] ? DW'(-r4_day) : DW'(r4_day);
            r5_negx <= r4_dax[DW-1] != r4_sn[NW-1];
            r5_negy <= r4_day[DW-1] != r4_sn[NW-1];
            r5_x1   <= r4_x1;
            r5_y1   <= r4_y1;
        end
    end

    // stage 6 feeds divider step 0; steps 1..QW each resolve one quotient bit
    logic                r_dv   [0:QW];
    logic                r_dhit [0:QW];
    logic                r_dngx [0:QW];
    logic                r_dngy [0:QW];
    logic [NW-1:0]       r_dden [0:QW];
    logic signed [C-1:0] r_dx1  [0:QW];
    logic signed [C-1:0] r_dy1  [0:QW];
    logic [NW-1:0]       r_remx [0:QW];
    logic [NW-1:0]       r_remy [0:QW];
    logic [QW-1:0]       r_nqx  [0:QW];
    logic [QW-1:0]       r_nqy  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dhit[0] <= r5_hit;
            r_dngx[0] <= r5_negx;
            r_dngy[0] <= r5_negy;
            r_dden[0] <= r5_den;
            r_dx1[0]  <= r5_x1;
            r_dy1[0]  <= r5_y1;
            r_remx[0] <= '0;
            r_remy[0] <= '0;
            r_nqx[0]  <= QW'(r5_sm) * QW'(r5_adx);
            r_nqy[0]  <= QW'(r5_sm) * QW'(r5_ady);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [NW:0] shx, shy;
        logic        gex, gey;

        assign shx = {r_remx[k], r_nqx[k][QW-1]};
        assign shy = {r_remy[k], r_nqy[k][QW-1]};
        assign gex = shx >= {1'b0, r_dden[k]};
        assign gey = shy >= {1'b0, r_dden[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dhit[k+1] <= r_dhit[k];
                r_dngx[k+1] <= r_dngx[k];
                r_dngy[k+1] <= r_dngy[k];
                r_dden[k+1] <= r_dden[k];
                r_dx1[k+1]  <= r_dx1[k];
                r_dy1[k+1]  <= r_dy1[k];
                r_remx[k+1] <= gex ? NW'(shx - {1'b0, r_dden[k]}) : NW'(shx);
                r_remy[k+1] <= gey ? NW'(shy - {1'b0, r_dden[k]}) : NW'(shy);
                r_nqx[k+1]  <= {r_nqx[k][QW-2:0], gex};
                r_nqy[k+1]  <= {r_nqy[k][QW-2:0], gey};
            end
        end
    end

    // saturating add of the quotient to the base point, returns {clip, value}
    function automatic logic [C:0] place(input logic signed [C-1:0] base,
                                         input logic [QW-1:0] q, input logic neg);
        logic              big;
        logic signed [C+2:0] qs;
        logic signed [C+2:0] v;
        logic [C:0]        res;
        big = |q[QW-1:C+1];
        qs  = signed'({2'b00, q[C:0]});
        v   = (C+3)'(base) + (neg ? -qs : qs);
        if (big) begin
            res = {1'b1, neg ? CMIN : CMAX};
        end else if (v > (C+3)'(CMAX)) begin
            res = {1'b1, CMAX};
        end else if (v < (C+3)'(CMIN)) begin
            res = {1'b1, CMIN};
        end else begin
            res = {1'b0, v[C-1:0]};
        end
        return res;
    endfunction

    logic [C:0] px, py;
    t_seg_out   n_out;

    assign px = place(r_dx1[QW], r_nqx[QW], r_dngx[QW]);
    assign py = place(r_dy1[QW], r_nqy[QW], r_dngy[QW]);

    always_comb begin
        n_out = '0;
        if (r_dhit[QW]) begin
            n_out.hit     = 1'b1;
            n_out.point_x = px[C-1:0];
            n_out.point_y = py[C-1:0];
            n_out.clipped = px[C] || py[C];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_data <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |->
            o_out_data.point_x == '0 && o_out_data.point_y == '0 && !o_out_data.clipped)
        else $error("no-hit result carries nonzero fields");

    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clipped |->
            o_out_data.point_x == CMAX || o_out_data.point_x == CMIN ||
            o_out_data.point_y == CMAX || o_out_data.point_y == CMIN)
        else $error("clipped result not at a coordinate limit");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QW] && r_dhit[QW] |-> r_remx[QW] < r_dden[QW] && r_remy[QW] < r_dden[QW])
        else $error("divider remainder not below denominator");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v1)
        else $error("accepted transfer not captured in first stage");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench
    import segi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS;
    localparam int NUM_RANDOM = 640;
    localparam int LATENCY = 7 + QW;
    localparam longint CYCLE_LIMIT = 400000;

    class intersect_board;
        t_seg_out pending[$];
        int errors;
        int hits;
        int clips;
        int transfers;

        function new();
            errors = 0;
            hits = 0;
            clips = 0;
            transfers = 0;
        endfunction

        function void note_pair(t_seg_in p);
            pending.push_back(solve_pair(p));
        endfunction

        // trunc(delta*num/den) added to base, saturated; den is positive
        function automatic longint place(longint base, longint delta, logic signed [127:0] num,
                                         logic signed [127:0] den, ref bit clip);
            logic signed [127:0] q;
            longint maxv;
            longint minv;
            logic signed [127:0] v;
            maxv = (longint'(1) <<< (CB - 1)) - 1;
            minv = -maxv - 1;
            q = (num * delta) / den;
            v = q + base;
            if (v > maxv) begin
                clip = 1;
                return maxv;
            end
            if (v < minv) begin
                clip = 1;
                return minv;
            end
            return longint'(v);
        endfunction

        function automatic t_seg_out solve_pair(t_seg_in p);
            t_seg_out r;
            longint x1, y1, x2, y2, x3, y3, x4, y4;
            longint dax, day, dbx, dby, wx, wy;
            logic signed [127:0] den, snum, tnum;
            bit clip;
            bit t_ok, s_ok;
            longint px, py;
            x1 = p.first_start_x;
            y1 = p.first_start_y;
            x2 = p.first_end_x;
            y2 = p.first_end_y;
            x3 = p.second_start_x;
            y3 = p.second_start_y;
            x4 = p.second_end_x;
            y4 = p.second_end_y;
            dax = x2 - x1;
            day = y2 - y1;
            dbx = x4 - x3;
            dby = y4 - y3;
            wx = x3 - x1;
            wy = y3 - y1;
            den = 128'(dbx * day) - 128'(dax * dby);
            snum = 128'(dbx * wy) - 128'(wx * dby);
            tnum = 128'(dax * wy) - 128'(wx * day);
            r = '0;
            clip = 0;
            if (den != 0) begin
                if (den < 0) begin
                    den = -den;
                    snum = -snum;
                    tnum = -tnum;
                end
                t_ok = tnum >= 0 && tnum <= den;
                s_ok = snum >= 0 && snum <= den;
                if (t_ok && (s_ok || p.extend_first)) begin
                    px = place(x1, dax, snum, den, clip);
                    py = place(y1, day, snum, den, clip);
                    r.hit = 1;
                    r.point_x = px[CB-1:0];
                    r.point_y = py[CB-1:0];
                    r.clipped = clip;
                end
            end
            return r;
        endfunction

        function void check_result(t_seg_out got);
            t_seg_out want;
            transfers++;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit) hits++;
            if (got.clipped) clips++;
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.point_x !== want.point_x) begin
                $error("point_x: expected %0d actual %0d", want.point_x, got.point_x);
                errors++;
            end
            if (got.point_y !== want.point_y) begin
                $error("point_y: expected %0d actual %0d", want.point_y, got.point_y);
                errors++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped: expected %0d actual %0d", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 0;
    logic     rst_n = 0;
    logic     in_valid = 0;
    logic     in_ready;
    t_seg_in  in_data = '0;
    logic     out_valid;
    logic     out_ready = 0;
    t_seg_out out_data;
    longint   cycles = 0;
    int       stall_mode = 0;

    intersect_board board = new();

    segment_intersection u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) board.note_pair(in_data);
        if (rst_n && out_valid && out_ready) board.check_result(out_data);
    end

    // receiver: phases of always-ready, random stalls and long stalls
    always @(posedge clk) begin
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic signed [CB-1:0] any_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return CB'($urandom_range(0, 64)) - CB'(32);
            default: return CB'($urandom);
        endcase
    endfunction

    // pair crafted to cross near a random point, endpoints around it
    function automatic t_seg_in crossing_pair();
        t_seg_in p;
        int cx, cy, r;
        r = $urandom_range(0, 3) == 0 ? 16000 : 800;
        cx = $urandom_range(0, 2 * r) - r;
        cy = $urandom_range(0, 2 * r) - r;
        p.first_start_x = CB'(cx - int'($urandom_range(0, r)));
        p.first_start_y = CB'(cy - int'($urandom_range(0, r)));
        p.first_end_x = CB'(cx + int'($urandom_range(0, r)));
        p.first_end_y = CB'(cy + int'($urandom_range(0, r)));
        p.second_start_x = CB'(cx + int'($urandom_range(0, r)));
        p.second_start_y = CB'(cy - int'($urandom_range(0, r)));
        p.second_end_x = CB'(cx - int'($urandom_range(0, r)));
        p.second_end_y = CB'(cy + int'($urandom_range(0, r)));
        p.extend_first = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic send_pair(t_seg_in p);
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    function automatic t_seg_in make_pair(int x1, int y1, int x2, int y2,
                                          int x3, int y3, int x4, int y4, bit ext);
        t_seg_in p;
        p.first_start_x = CB'(x1);
        p.first_start_y = CB'(y1);
        p.first_end_x = CB'(x2);
        p.first_end_y = CB'(y2);
        p.second_start_x = CB'(x3);
        p.second_start_y = CB'(y3);
        p.second_end_x = CB'(x4);
        p.second_end_y = CB'(y4);
        p.extend_first = ext;
        return p;
    endfunction

    initial begin
        t_seg_in p;
        int burst;
        int sent;
        int drain;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cross with negative den, diagonal cross, touching ends, parallel, collinear, cross with positive den
        send_pair(make_pair(-16, 0, 16, 0, 0, -16, 0, 16, 0));
        send_pair(make_pair(0, 0, 16, 16, 16, 0, 0, 16, 0));
        send_pair(make_pair(0, 0, 16, 0, 16, 0, 32, 16, 0));
        send_pair(make_pair(0, 0, 16, 0, 0, 16, 16, 16, 0));
        send_pair(make_pair(0, 0, 16, 0, 32, 0, 48, 0, 1));
        send_pair(make_pair(0, -16, 0, 16, -16, 0, 16, 0, 0));
        // off the end of A: miss unless extended
        send_pair(make_pair(0, 0, 16, 0, 64, -16, 64, 16, 0));
        send_pair(make_pair(0, 0, 16, 0, 64, -16, 64, 16, 1));
        // extensions reaching the coordinate limits, then corner and degenerate pairs
        send_pair(make_pair(0, 0, 1, 1, 32767, -32768, 32767, 32767, 1));
        send_pair(make_pair(0, 0, -1, -1, -32768, -32768, -32768, 32767, 1));
        send_pair(make_pair(0, 0, 1, 0, -32768, -32768, -32768, 32767, 1));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 1));
        send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, 0));
        send_pair(make_pair(0, 0, 3, 7, 5, 0, 0, 5, 0));
        send_pair(make_pair(0, 0, -3, 7, 5, 0, 0, 5, 1));
        send_pair(make_pair(1, 0, 2, 100, 0, 50, 300, 50, 1));
        sent = 19;

        while (sent < 19 + NUM_RANDOM) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (burst) begin
                if ($urandom_range(0, 3) == 0) begin
                    p = make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                                  any_coord(), any_coord(), any_coord(), any_coord(),
                                  1'($urandom_range(0, 1)));
                end else begin
                    p = crossing_pair();
                end
                send_pair(p);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        drain = 0;
        while (drain < 4 * LATENCY) begin
            @(posedge clk);
            drain++;
        end

        $display("%0d segment pairs checked, %0d intersections found, %0d saturated points",
                 board.transfers, board.hits, board.clips);
        if (board.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ segment_intersection.f @@
sv/segi_pkg.sv
sv/segment_intersection.sv
tb/testbench.sv
